@@ rtl/kme_pkg.sv @@
// ----------------------------------------------------------------------------
// kme_pkg
// Shared types and constants for the mouse-keys emulator core.
// ----------------------------------------------------------------------------
package kme_pkg;

   localparam int unsigned TickWidth = 18;
   localparam int unsigned ThrWidth  = 16;

   localparam logic [ThrWidth-1:0]  THR_RESET = 16'd19;
   localparam logic [TickWidth-1:0] TICK_MAX  = 18'h3FFFF;

   // function codes
   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // key states
   localparam logic [3:0] ST_PRESSED  = 4'd1;
   localparam logic [3:0] ST_HOLD     = 4'd2;
   localparam logic [3:0] ST_RELEASED = 4'd3;

   // scancodes
   localparam logic [7:0] SC_RSHIFT   = 8'hA3;
   localparam logic [7:0] SC_RIGHT    = 8'hB7;
   localparam logic [7:0] SC_LEFT     = 8'hB4;
   localparam logic [7:0] SC_DOWN     = 8'hB6;
   localparam logic [7:0] SC_UP       = 8'hB5;
   localparam logic [7:0] SC_RBRACKET = 8'h5D;
   localparam logic [7:0] SC_LBRACKET = 8'h5B;

   // direction bits
   localparam logic [3:0] DIR_LEFT  = 4'b0001;
   localparam logic [3:0] DIR_RIGHT = 4'b0010;
   localparam logic [3:0] DIR_UP    = 4'b0100;
   localparam logic [3:0] DIR_DOWN  = 4'b1000;

   // event kinds
   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_SCAN   = 3'd1;
   localparam logic [2:0] KIND_KEY    = 3'd2;
   localparam logic [2:0] KIND_LEFT   = 3'd3;
   localparam logic [2:0] KIND_RIGHT  = 3'd4;
   localparam logic [2:0] KIND_MOTION = 3'd5;

   typedef struct packed {
      logic       func;
      logic [3:0] key_state;
      logic [7:0] scan_code;
   } req_type;

   typedef struct packed {
      logic [2:0]        event_kind;
      logic [7:0]        report_code;
      logic              is_down;
      logic signed [3:0] move_x;
      logic signed [3:0] move_y;
      logic              mouse_on;
   } rsp_type;

   typedef struct packed {
      logic                 mouse_on;
      logic [3:0]           dir;
      logic [TickWidth-1:0] elapsed;
   } kme_state_type;

endpackage

@@ rtl/keyboard_mouse_key_emulator_core.sv @@
// ----------------------------------------------------------------------------
// keyboard_mouse_key_emulator_core
// Mouse-keys emulator: key events and timer ticks in, one report out each.
// ----------------------------------------------------------------------------
// Each accepted transaction yields exactly one result transaction, in order.
// The core takes one transaction per cycle while the result side keeps taking:
// an input register feeds the combinational step, whose result and state
// update are captured together in the result register, which then offers
// the result; both registers hold while the result side stalls.
module keyboard_mouse_key_emulator_core
   import kme_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [ThrWidth-1:0] csr_wdata
);

   logic                in_valid_ff;
   req_type             in_data_ff;
   logic                out_valid_ff;
   rsp_type             out_data_ff;
   kme_state_type       state_ff;
   kme_state_type       state_in;
   rsp_type             result_in;
   logic [ThrWidth-1:0] thr_ff;
   logic                advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   kme_step u_step (
      .item      (in_data_ff),
      .threshold (thr_ff),
      .cur       (state_ff),
      .nxt       (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         thr_ff       <= THR_RESET;
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result_in;
      end
   end

   // motion only on a tick in mouse mode
   a_motion_mode: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_data_ff.event_kind == KIND_MOTION) |-> out_data_ff.mouse_on)
      else $error("motion reported outside mouse mode");

   // no movement on non-motion results
   a_still: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_data_ff.event_kind != KIND_MOTION)
      |-> (out_data_ff.move_x == 4'sd0) && (out_data_ff.move_y == 4'sd0))
      else $error("movement on a non-motion result");

   // a held input transaction is not dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input transaction lost while stalled");

   // state changes only when a transaction moves through
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a transaction");

endmodule

@@ rtl/kme_step.sv @@
// ----------------------------------------------------------------------------
// kme_step
// Combinational transaction step: current state and one item in, next state
// and one result out.
// ----------------------------------------------------------------------------
module kme_step
   import kme_pkg::*;
(
   input  req_type             item,
   input  logic [ThrWidth-1:0] threshold,
   input  kme_state_type       cur,
   output kme_state_type       nxt,
   output rsp_type             result
);

   logic [TickWidth-1:0] thr_ext;
   logic [TickWidth-1:0] thr_x3;
   logic [TickWidth-1:0] ticks;
   logic [2:0]           step_mag;
   logic signed [3:0]    mag_s;
   logic [3:0]           arrow_bit;
   logic                 is_arrow;
   logic                 handled;
   logic                 valid_state;

   assign thr_ext = {{(TickWidth-ThrWidth){1'b0}}, threshold};
   assign thr_x3  = {thr_ext[TickWidth-2:0], 1'b0} + thr_ext;
   assign ticks   = (cur.elapsed == TICK_MAX) ? cur.elapsed
                                              : cur.elapsed + {{(TickWidth-1){1'b0}}, 1'b1};

   always_comb begin
      priority if (ticks <= thr_ext) begin
         step_mag = 3'd1;
      end else if (ticks <= thr_x3) begin
         step_mag = 3'd2;
      end else begin
         step_mag = 3'd4;
      end
   end

   assign mag_s = signed'({1'b0, step_mag});

   always_comb begin
      unique case (item.scan_code)
         SC_RIGHT: begin arrow_bit = DIR_RIGHT; is_arrow = 1'b1; end
         SC_LEFT:  begin arrow_bit = DIR_LEFT;  is_arrow = 1'b1; end
         SC_DOWN:  begin arrow_bit = DIR_DOWN;  is_arrow = 1'b1; end
         SC_UP:    begin arrow_bit = DIR_UP;    is_arrow = 1'b1; end
         default:  begin arrow_bit = 4'b0000;   is_arrow = 1'b0; end
      endcase
   end

   assign valid_state = (item.key_state == ST_PRESSED) || (item.key_state == ST_HOLD)
                        || (item.key_state == ST_RELEASED);

   always_comb begin
      nxt                = cur;
      result             = '0;
      handled            = 1'b0;
      if (item.func == FUNC_TICK) begin
         nxt.elapsed = ticks;
         if (cur.mouse_on && (cur.dir != 4'b0000)) begin
            result.event_kind = KIND_MOTION;
            result.move_x     = ((cur.dir & DIR_RIGHT) != 4'b0000 ? mag_s : 4'sd0)
                              - ((cur.dir & DIR_LEFT)  != 4'b0000 ? mag_s : 4'sd0);
            result.move_y     = ((cur.dir & DIR_DOWN)  != 4'b0000 ? mag_s : 4'sd0)
                              - ((cur.dir & DIR_UP)    != 4'b0000 ? mag_s : 4'sd0);
         end
      end else if (valid_state) begin
         if (item.scan_code == SC_RSHIFT) begin
            handled = 1'b1;
            if (item.key_state == ST_PRESSED) begin
               nxt.mouse_on = ~cur.mouse_on;
            end
         end else if (cur.mouse_on) begin
            if (is_arrow) begin
               handled = 1'b1;
               if (item.key_state == ST_PRESSED) begin
                  if ((cur.dir & arrow_bit) == 4'b0000) begin
                     nxt.elapsed = '0;
                  end
                  nxt.dir = cur.dir | arrow_bit;
               end else if (item.key_state == ST_RELEASED) begin
                  nxt.dir = cur.dir & ~arrow_bit;
               end
            end else if (item.scan_code == SC_RBRACKET) begin
               handled           = 1'b1;
               result.event_kind = KIND_LEFT;
               result.is_down    = (item.key_state == ST_PRESSED);
            end else if (item.scan_code == SC_LBRACKET) begin
               handled           = 1'b1;
               result.event_kind = KIND_RIGHT;
               result.is_down    = (item.key_state == ST_PRESSED);
            end
         end
         if (!handled) begin
            result.report_code = item.scan_code;
            if (item.key_state == ST_HOLD) begin
               result.event_kind = KIND_SCAN;
            end else begin
               result.event_kind = KIND_KEY;
               result.is_down    = (item.key_state == ST_PRESSED);
            end
         end
      end
      result.mouse_on = nxt.mouse_on;
   end

endmodule

@@ test/keyboard_mouse_key_emulator_core_tb.sv @@
// ----------------------------------------------------------------------------
// keyboard_mouse_key_emulator_core_tb
// Self-checking bench for the mouse-keys emulator core. Key events and timer
// ticks go in on the request channel under random idle bursts. A scoreboard
// predicts every report: mode toggle, arrow direction bits, button and
// passthrough reports, and motion steps against the threshold. Each response
// is compared field by field. Phases run at several threshold settings,
// among them zero and one, and one phase holds an arrow long enough to pass
// through all three step sizes.
// ----------------------------------------------------------------------------
module keyboard_mouse_key_emulator_core_tb;
   import kme_pkg::*;

   localparam int unsigned CycleLimit = 1_500_000;

   class mouse_keys_scoreboard;
      rsp_type              expected_q[$];
      bit                   mode_on;
      logic [3:0]           held_dirs;
      logic [TickWidth-1:0] tick_count;
      logic [ThrWidth-1:0]  threshold;
      int unsigned          errors;
      int unsigned          checked;
      int unsigned          motions;

      function new();
         mode_on    = 1'b0;
         held_dirs  = '0;
         tick_count = '0;
         threshold  = THR_RESET;
         errors     = 0;
         checked    = 0;
         motions    = 0;
      endfunction

      function void set_threshold(logic [ThrWidth-1:0] value);
         threshold = value;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function void arrow_key(logic [3:0] dir_mask, logic [3:0] st);
         if (st == ST_PRESSED) begin
            if ((held_dirs & dir_mask) == 4'b0)
               tick_count = '0;
            held_dirs |= dir_mask;
         end else if (st == ST_RELEASED) begin
            held_dirs &= ~dir_mask;
         end
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int      step;
         int      dx;
         int      dy;
         bit      handled;
         e = '0;
         dx = 0;
         dy = 0;
         handled = 1'b0;
         if (r.func == FUNC_TICK) begin
            if (tick_count != TICK_MAX)
               tick_count++;
            if (mode_on && held_dirs != 4'b0) begin
               if (tick_count <= threshold)
                  step = 1;
               else if (32'(tick_count) <= 32'(threshold) * 3)
                  step = 2;
               else
                  step = 4;
               if ((held_dirs & DIR_LEFT) != 0)  dx -= step;
               if ((held_dirs & DIR_RIGHT) != 0) dx += step;
               if ((held_dirs & DIR_DOWN) != 0)  dy += step;
               if ((held_dirs & DIR_UP) != 0)    dy -= step;
               e.event_kind = KIND_MOTION;
               e.move_x = 4'(dx);
               e.move_y = 4'(dy);
               motions++;
            end
         end else if (r.key_state inside {ST_PRESSED, ST_HOLD, ST_RELEASED}) begin
            if (r.scan_code == SC_RSHIFT) begin
               if (r.key_state == ST_PRESSED)
                  mode_on = !mode_on;
               handled = 1'b1;
            end else if (mode_on) begin
               handled = 1'b1;
               case (r.scan_code)
                  SC_RIGHT: arrow_key(DIR_RIGHT, r.key_state);
                  SC_LEFT:  arrow_key(DIR_LEFT, r.key_state);
                  SC_DOWN:  arrow_key(DIR_DOWN, r.key_state);
                  SC_UP:    arrow_key(DIR_UP, r.key_state);
                  SC_RBRACKET: begin
                     e.event_kind = KIND_LEFT;
                     e.is_down = (r.key_state == ST_PRESSED);
                  end
                  SC_LBRACKET: begin
                     e.event_kind = KIND_RIGHT;
                     e.is_down = (r.key_state == ST_PRESSED);
                  end
                  default: handled = 1'b0;
               endcase
            end
            if (!handled) begin
               e.report_code = r.scan_code;
               if (r.key_state == ST_HOLD) begin
                  e.event_kind = KIND_SCAN;
               end else begin
                  e.event_kind = KIND_KEY;
                  e.is_down = (r.key_state == ST_PRESSED);
               end
            end
         end
         e.mouse_on = mode_on;
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic signed [8:0] want,
                                  logic signed [8:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("response with no transaction outstanding: %h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("event_kind", want.event_kind, got.event_kind);
         compare_field("report_code", want.report_code, got.report_code);
         compare_field("is_down", want.is_down, got.is_down);
         compare_field("move_x", want.move_x, got.move_x);
         compare_field("move_y", want.move_y, got.move_y);
         compare_field("mouse_on", want.mouse_on, got.mouse_on);
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we = 1'b0;
   logic [ThrWidth-1:0] csr_wdata = '0;

   mouse_keys_scoreboard sb = new();

   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          tick_run = 0;
   int unsigned cycle_count = 0;
   int unsigned threshold_writes = 0;
   logic [7:0]  arrow_codes [4] = '{SC_LEFT, SC_RIGHT, SC_UP, SC_DOWN};

   keyboard_mouse_key_emulator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_data);
      end
   end

   // result side back-pressure
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_item(input logic f, input logic [3:0] st, input logic [7:0] sc);
      req_type r;
      r.func = f;
      r.key_state = st;
      r.scan_code = sc;
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic change_threshold(input logic [ThrWidth-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      sb.set_threshold(value);
      threshold_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(input int count);
      int         pick;
      logic       f;
      logic [3:0] st;
      logic [7:0] sc;
      repeat (count) begin
         f = FUNC_KEY;
         st = 4'($urandom_range(ST_PRESSED, ST_RELEASED));
         sc = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (tick_run == 0 && pick < 30)
            tick_run = $urandom_range(1, 70);
         if (tick_run > 0) begin
            tick_run--;
            f = FUNC_TICK;
            st = 4'($urandom_range(0, 15));
         end else if (pick < 55) begin
            sc = arrow_codes[$urandom_range(0, 3)];
            pick = $urandom_range(0, 99);
            st = (pick < 50) ? ST_PRESSED : (pick < 85) ? ST_RELEASED : ST_HOLD;
         end else if (pick < 63) begin
            sc = $urandom_range(0, 1) ? SC_RBRACKET : SC_LBRACKET;
         end else if (pick < 67) begin
            sc = SC_RSHIFT;
            if ($urandom_range(0, 3) != 0)
               st = ST_PRESSED;
         end else if (pick >= 85) begin
            // noise: any function and any key state
            f = 1'($urandom_range(0, 1));
            st = 4'($urandom_range(0, 15));
         end
         send_item(f, st, sc);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 20;
      rsp_stall_pct = 20;

      // mode off: ticks, passthrough and ignored states
      send_item(FUNC_TICK, 4'd0, 8'h00);
      send_item(FUNC_KEY, ST_PRESSED, 8'h00);
      send_item(FUNC_KEY, ST_HOLD, 8'hFF);
      send_item(FUNC_KEY, ST_RELEASED, 8'hFF);
      send_item(FUNC_KEY, 4'd0, 8'h41);
      send_item(FUNC_KEY, 4'd4, 8'h41);
      send_item(FUNC_KEY, 4'd15, 8'hFF);
      send_item(FUNC_KEY, ST_HOLD, SC_RSHIFT);
      send_item(FUNC_KEY, ST_RELEASED, SC_RSHIFT);
      send_item(FUNC_KEY, ST_PRESSED, SC_UP);
      // mode on: arrows, opposite directions, buttons
      send_item(FUNC_KEY, ST_PRESSED, SC_RSHIFT);
      send_item(FUNC_KEY, ST_PRESSED, SC_RIGHT);
      send_item(FUNC_KEY, ST_PRESSED, SC_DOWN);
      send_item(FUNC_TICK, 4'd15, 8'hFF);
      send_item(FUNC_KEY, ST_PRESSED, SC_LEFT);
      send_item(FUNC_TICK, ST_PRESSED, SC_RSHIFT);
      send_item(FUNC_KEY, ST_PRESSED, SC_UP);
      send_item(FUNC_TICK, 4'd0, 8'h00);
      send_item(FUNC_KEY, ST_PRESSED, SC_RBRACKET);
      send_item(FUNC_KEY, ST_HOLD, SC_RBRACKET);
      send_item(FUNC_KEY, ST_PRESSED, SC_LBRACKET);
      send_item(FUNC_KEY, ST_RELEASED, SC_LBRACKET);
      send_item(FUNC_KEY, ST_HOLD, SC_UP);
      send_item(FUNC_KEY, ST_HOLD, 8'h41);
      // mode off keeps the direction bits
      send_item(FUNC_KEY, ST_PRESSED, SC_RSHIFT);
      send_item(FUNC_TICK, 4'd0, 8'h00);
      send_item(FUNC_KEY, ST_PRESSED, SC_RSHIFT);
      send_item(FUNC_TICK, 4'd0, 8'h00);

      run_random(150);
      change_threshold(16'd1);
      run_random(150);
      req_idle_pct = 5;
      rsp_stall_pct = 40;
      change_threshold(16'd0);
      run_random(120);
      req_idle_pct = 40;
      rsp_stall_pct = 10;
      change_threshold(16'($urandom_range(2, 12)));
      run_random(150);

      // held arrow through step sizes one, two and four
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      change_threshold(16'd10);
      if (!sb.mode_on)
         send_item(FUNC_KEY, ST_PRESSED, SC_RSHIFT);
      foreach (arrow_codes[i])
         send_item(FUNC_KEY, ST_RELEASED, arrow_codes[i]);
      send_item(FUNC_KEY, ST_PRESSED, SC_DOWN);
      repeat (40)
         send_item(FUNC_TICK, 4'd0, 8'h00);

      change_threshold(16'($urandom_range(3, 8)));
      run_random(180);

      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("checked %0d transactions, %0d of them motion, over %0d threshold writes",
               sb.checked, sb.motions, threshold_writes);
      $display("mode toggles, arrows, buttons, passthrough keys and all three step sizes");
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
